### design/tpls_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-point scaler package
// Widths, stage map, register indices and shared types.
// ----------------------------------------------------------------------------
package tpls_pkg;

	// sample and calibration point width
	localparam int W   = 16;
	// differences of two W-bit values
	localparam int AW  = W + 1;
	// products of two differences
	localparam int PW  = 2 * AW;
	// numerator, one guard bit above the products
	localparam int NW  = PW + 1;
	// quotient bits kept; anything larger saturates
	localparam int QW  = W + 1;
	// stream data width, rounded up to whole bytes
	localparam int TDW = ((W + 7) / 8) * 8;

	// stage map: 5 front stages, QW divide steps, sign stage, clamp stage
	localparam int ST_DIV0 = 5;
	localparam int ST_SIGN = ST_DIV0 + QW;
	localparam int ST_OUT  = ST_SIGN + 1;
	localparam int NS      = ST_OUT + 1;

	// configuration register indices
	localparam int CIW = 2;
	localparam logic [CIW-1:0] REG_P1X = 2'd0;
	localparam logic [CIW-1:0] REG_P1Y = 2'd1;
	localparam logic [CIW-1:0] REG_P2X = 2'd2;
	localparam logic [CIW-1:0] REG_P2Y = 2'd3;

	// reset value of the second point: largest positive sample
	localparam logic [W-1:0] P2_RESET = {1'b0, {(W-1){1'b1}}};

	typedef struct packed {
		logic signed [W-1:0]  x1;
		logic signed [W-1:0]  y1;
		logic signed [AW-1:0] dx;
		logic signed [AW-1:0] dy;
		logic [AW-1:0]        dmag;
		logic                 dx_neg;
		logic signed [W-1:0]  lo;
		logic signed [W-1:0]  hi;
		logic                 err;
	} cfg_t;

	typedef struct packed {
		logic [NS-1:0] en;
		logic [NS-1:0] vld;
	} pipe_ctl_t;

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [QW-1:0] quo;
		logic          ovf;
		logic          neg;
	} div_t;

endpackage
`default_nettype wire

### design/tpls_cfg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-point scaler configuration
// Point registers and the line constants derived from them.
// ----------------------------------------------------------------------------
module tpls_cfg (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [tpls_pkg::CIW-1:0]     cfg_index,
	input  wire logic [tpls_pkg::W-1:0]       cfg_data,
	output tpls_pkg::cfg_t                    cfg
);

	logic signed [tpls_pkg::W-1:0]  x1_q, y1_q, x2_q, y2_q;
	logic signed [tpls_pkg::AW-1:0] dx_c, dy_c;
	logic signed [tpls_pkg::AW-1:0] dx_q, dy_q;
	logic [tpls_pkg::AW-1:0]        dmag_q;
	logic                           dx_neg_q, err_q;
	logic signed [tpls_pkg::W-1:0]  lo_q, hi_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x1_q <= '0;
			y1_q <= '0;
			x2_q <= tpls_pkg::P2_RESET;
			y2_q <= tpls_pkg::P2_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				tpls_pkg::REG_P1X: x1_q <= cfg_data;
				tpls_pkg::REG_P1Y: y1_q <= cfg_data;
				tpls_pkg::REG_P2X: x2_q <= cfg_data;
				tpls_pkg::REG_P2Y: y2_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign dx_c = {x2_q[tpls_pkg::W-1], x2_q} - {x1_q[tpls_pkg::W-1], x1_q};
	assign dy_c = {y2_q[tpls_pkg::W-1], y2_q} - {y1_q[tpls_pkg::W-1], y1_q};

	// derived constants follow the point registers in the next cycle
	always_ff @(posedge clk) begin
		dx_q     <= dx_c;
		dy_q     <= dy_c;
		dx_neg_q <= dx_c[tpls_pkg::AW-1];
		dmag_q   <= dx_c[tpls_pkg::AW-1] ? (tpls_pkg::AW'(0) - dx_c) : dx_c;
		err_q    <= (x1_q == x2_q);
		lo_q     <= (y1_q < y2_q) ? y1_q : y2_q;
		hi_q     <= (y1_q < y2_q) ? y2_q : y1_q;
	end

	always_comb begin
		cfg.x1     = x1_q;
		cfg.y1     = y1_q;
		cfg.dx     = dx_q;
		cfg.dy     = dy_q;
		cfg.dmag   = dmag_q;
		cfg.dx_neg = dx_neg_q;
		cfg.lo     = lo_q;
		cfg.hi     = hi_q;
		cfg.err    = err_q;
	end

endmodule
`default_nettype wire

### design/tpls_ctl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-point scaler pipeline control
// Per-stage valid bits and load enables; a stage loads when it is empty or
// when every stage after it can move.
// ----------------------------------------------------------------------------
module tpls_ctl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           out_ready,
	output tpls_pkg::pipe_ctl_t pc
);

	logic [tpls_pkg::NS-1:0] vld_q;
	logic [tpls_pkg::NS-1:0] en;

	// a stage may load if the sink takes a beat or some stage at or after it is empty
	always_comb begin
		logic [tpls_pkg::NS-1:0] below;
		for (int i = 0; i < tpls_pkg::NS; i++) begin
			below = (tpls_pkg::NS'(1) << i) - tpls_pkg::NS'(1);
			en[i] = out_ready || ((vld_q | below) != {tpls_pkg::NS{1'b1}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & {vld_q[tpls_pkg::NS-2:0], in_valid}) | (~en & vld_q);
		end
	end

	assign pc.en  = en;
	assign pc.vld = vld_q;

endmodule
`default_nettype wire

### design/tpls_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-point scaler divider
// Restoring divider, one quotient bit per register stage, MSB first.
// ----------------------------------------------------------------------------
module tpls_div (
	input  wire logic                      clk,
	input  wire logic [tpls_pkg::QW-1:0]   en,
	input  wire logic [tpls_pkg::AW-1:0]   dmag,
	input  wire tpls_pkg::div_t            din,
	output tpls_pkg::div_t                 dout
);

	tpls_pkg::div_t step_sk [tpls_pkg::QW];
	tpls_pkg::div_t nxt     [tpls_pkg::QW];

	for (genvar k = 0; k < tpls_pkg::QW; k++) begin : g_step
		localparam int BIT = tpls_pkg::QW - 1 - k;
		tpls_pkg::div_t          prv;
		logic [tpls_pkg::NW-1:0] sub;
		logic                    ge;

		if (k == 0) begin : g_first
			assign prv = din;
		end else begin : g_rest
			assign prv = step_sk[k-1];
		end

		assign sub = tpls_pkg::NW'(dmag) << BIT;
		assign ge  = (prv.rem >= sub);

		always_comb begin
			nxt[k]          = prv;
			nxt[k].rem      = ge ? (prv.rem - sub) : prv.rem;
			nxt[k].quo[BIT] = ge;
		end

		always_ff @(posedge clk) begin
			if (en[k]) begin
				step_sk[k] <= nxt[k];
			end
		end
	end

	assign dout = step_sk[tpls_pkg::QW-1];

endmodule
`default_nettype wire

### design/two_point_linear_scaler.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Two-point linear scaler
// Maps a raw sample onto the line through two calibration points, clamped.
// ----------------------------------------------------------------------------
// Each input beat yields one output beat: the sample x is mapped to
// (x*(y2-y1) + y1*x2 - y2*x1) / (x2-x1), truncated toward zero, then clamped
// to the range between y1 and y2. With x1 equal to x2 the output is 0 and the
// error flag in tuser is set. One beat is taken per clock unless backpressure
// holds the pipe. The pipeline is built from five front stages (offset, two
// parallel multiplies, sum, magnitude, range check), W + 1 restoring divide
// steps that each produce one quotient bit, a sign stage and a clamp stage.
// Backpressure stalls only the stages that are full, so bubbles are squeezed
// out. Write the point registers only while no beat is in flight; the line
// constants derived from them settle in the cycle after a write.
// ----------------------------------------------------------------------------
module two_point_linear_scaler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	// configuration write channel
	input  wire logic                        cfg_valid,
	output logic                             cfg_ready,
	input  wire logic [tpls_pkg::CIW-1:0]    cfg_index,
	input  wire logic [tpls_pkg::W-1:0]      cfg_data,
	// sample stream in
	input  wire logic                        s_axis_tvalid,
	output logic                             s_axis_tready,
	input  wire logic [tpls_pkg::TDW-1:0]    s_axis_tdata,   // raw_sample
	// scaled stream out
	output logic                             m_axis_tvalid,
	input  wire logic                        m_axis_tready,
	output logic [tpls_pkg::TDW-1:0]         m_axis_tdata,   // scaled_value
	output logic                             m_axis_tuser    // degenerate_error
);

	tpls_pkg::cfg_t      cfg;
	tpls_pkg::pipe_ctl_t pc;

	// signed views of the configuration
	logic signed [tpls_pkg::W-1:0]  c_x1, c_y1, c_lo, c_hi;
	logic signed [tpls_pkg::AW-1:0] c_dx, c_dy;

	logic signed [tpls_pkg::W-1:0]  raw;
	logic signed [tpls_pkg::AW-1:0] ofs_s1;
	logic signed [tpls_pkg::PW-1:0] prod_s2, base_s2;
	logic signed [tpls_pkg::NW-1:0] num_s3;
	logic                           neg_s4;
	logic [tpls_pkg::NW-1:0]        mag_s4;
	tpls_pkg::div_t                 pre_s5, div_out;
	logic signed [tpls_pkg::QW:0]   qs_s23;
	logic                           ovf_s23, neg_s23;
	logic [tpls_pkg::W-1:0]         scaled_s24;
	logic                           err_s24;

	logic signed [tpls_pkg::QW:0]   lo_x, hi_x;
	logic [tpls_pkg::QW:0]          quo_x;
	logic [tpls_pkg::W-1:0]         scaled_c;

	tpls_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tpls_ctl u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.out_ready (m_axis_tready),
		.pc        (pc)
	);

	assign c_x1 = cfg.x1;
	assign c_y1 = cfg.y1;
	assign c_lo = cfg.lo;
	assign c_hi = cfg.hi;
	assign c_dx = cfg.dx;
	assign c_dy = cfg.dy;

	assign raw           = s_axis_tdata[tpls_pkg::W-1:0];
	assign s_axis_tready = pc.en[0];

	// stage 1: offset from the first point
	always_ff @(posedge clk) begin
		if (pc.en[0]) begin
			ofs_s1 <= {raw[tpls_pkg::W-1], raw} - {c_x1[tpls_pkg::W-1], c_x1};
		end
	end

	// stage 2: numerator = (x-x1)*(y2-y1) + y1*(x2-x1); both products here
	always_ff @(posedge clk) begin
		if (pc.en[1]) begin
			prod_s2 <= ofs_s1 * c_dy;
			base_s2 <= c_y1 * c_dx;
		end
	end

	// stage 3: sum the products
	always_ff @(posedge clk) begin
		if (pc.en[2]) begin
			num_s3 <= {prod_s2[tpls_pkg::PW-1], prod_s2} + {base_s2[tpls_pkg::PW-1], base_s2};
		end
	end

	// stage 4: split into sign and magnitude
	always_ff @(posedge clk) begin
		if (pc.en[3]) begin
			neg_s4 <= num_s3[tpls_pkg::NW-1];
			mag_s4 <= num_s3[tpls_pkg::NW-1] ? (tpls_pkg::NW'(0) - num_s3) : num_s3;
		end
	end

	// stage 5: flag quotients too large for the divider; those clamp anyway
	always_ff @(posedge clk) begin
		if (pc.en[4]) begin
			pre_s5.rem <= mag_s4;
			pre_s5.quo <= '0;
			pre_s5.ovf <= (mag_s4 >= {{(tpls_pkg::NW - tpls_pkg::AW - tpls_pkg::QW){1'b0}},
				cfg.dmag, {tpls_pkg::QW{1'b0}}});
			pre_s5.neg <= neg_s4 ^ cfg.dx_neg;
		end
	end

	tpls_div u_div (
		.clk  (clk),
		.en   (pc.en[tpls_pkg::ST_DIV0 +: tpls_pkg::QW]),
		.dmag (cfg.dmag),
		.din  (pre_s5),
		.dout (div_out)
	);

	// sign stage: apply the quotient sign
	assign quo_x = {1'b0, div_out.quo};

	always_ff @(posedge clk) begin
		if (pc.en[tpls_pkg::ST_SIGN]) begin
			qs_s23  <= div_out.neg ? ((tpls_pkg::QW + 1)'(0) - quo_x) : quo_x;
			ovf_s23 <= div_out.ovf;
			neg_s23 <= div_out.neg;
		end
	end

	// clamp stage: saturate, clamp to the y range, force zero on equal x points
	assign lo_x = {{(tpls_pkg::QW + 1 - tpls_pkg::W){c_lo[tpls_pkg::W-1]}}, c_lo};
	assign hi_x = {{(tpls_pkg::QW + 1 - tpls_pkg::W){c_hi[tpls_pkg::W-1]}}, c_hi};

	always_comb begin
		if (cfg.err) begin
			scaled_c = '0;
		end else if (ovf_s23) begin
			scaled_c = neg_s23 ? c_lo : c_hi;
		end else if (qs_s23 < lo_x) begin
			scaled_c = c_lo;
		end else if (qs_s23 > hi_x) begin
			scaled_c = c_hi;
		end else begin
			scaled_c = qs_s23[tpls_pkg::W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pc.en[tpls_pkg::ST_OUT]) begin
			scaled_s24 <= scaled_c;
			err_s24    <= cfg.err;
		end
	end

	assign m_axis_tvalid = pc.vld[tpls_pkg::ST_OUT];
	assign m_axis_tdata  = tpls_pkg::TDW'(scaled_s24);
	assign m_axis_tuser  = err_s24;

`ifndef SYNTHESIS
	// an error beat carries a zero value
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser) |-> (m_axis_tdata[tpls_pkg::W-1:0] == '0))
		else $error("error beat with nonzero value");

	// a good beat lies between the two y points
	a_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tuser) |->
		(($signed(m_axis_tdata[tpls_pkg::W-1:0]) >= c_lo) &&
		 ($signed(m_axis_tdata[tpls_pkg::W-1:0]) <= c_hi)))
		else $error("scaled value outside clamp range");

	// the last divide step leaves a remainder below the divisor
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		(pc.vld[tpls_pkg::ST_SIGN-1] && !div_out.ovf && !cfg.err) |->
		(div_out.rem < tpls_pkg::NW'(cfg.dmag)))
		else $error("divider remainder not reduced");

	// an empty output stage lets the whole pipe move
	a_no_block: assert property (@(posedge clk) disable iff (!arst_n)
		!pc.vld[tpls_pkg::ST_OUT] |-> s_axis_tready)
		else $error("input stalled with output stage empty");
`endif

endmodule
`default_nettype wire

### verif/tb_two_point_linear_scaler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Two-point linear scaler testbench
// Streams signed samples through the scaler under several calibration lines
// and checks every output beat against a behavioural line-and-clamp predictor.
// ----------------------------------------------------------------------------
// The run opens with the reset calibration, then steps through a handful of
// hand-picked lines: full-range ascending, full-range descending, a line with
// the x points swapped, a very steep line and a degenerate one with both x
// points equal. After that come randomly drawn lines, each with a batch of
// random samples aimed mostly between the two x points so the unclamped part
// of the line gets exercised. Points are only rewritten once the scaler has
// drained. The sender moves in bursts with random gaps; the receiver switches
// between several stall patterns of its own.
// ----------------------------------------------------------------------------
module tb_two_point_linear_scaler;
	import tpls_pkg::*;

	localparam logic signed [W-1:0] SAMPLE_MIN = {1'b1, {(W-1){1'b0}}};
	localparam logic signed [W-1:0] SAMPLE_MAX = {1'b0, {(W-1){1'b1}}};
	localparam int RANDOM_LINES    = 12;
	localparam int SAMPLES_PER_LINE = 36;

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_COMB
	} rx_pattern_e;

	// one expected output beat: scaled_value in tdata, degenerate_error in tuser
	typedef struct {
		logic [TDW-1:0] data;
		logic           degenerate;
	} scaled_beat_t;

	logic             clk           = 1'b0;
	logic             arst_n        = 1'b0;
	logic             cfg_valid     = 1'b0;
	logic             cfg_ready;
	logic [CIW-1:0]   cfg_index     = REG_P1X;
	logic [W-1:0]     cfg_data      = '0;
	logic             s_axis_tvalid = 1'b0;
	logic             s_axis_tready;
	logic [TDW-1:0]   s_axis_tdata  = '0;   // raw_sample
	logic             m_axis_tvalid;
	logic             m_axis_tready = 1'b0;
	logic [TDW-1:0]   m_axis_tdata;          // scaled_value
	logic             m_axis_tuser;          // degenerate_error

	// calibration line as the scaler should currently hold it
	logic signed [W-1:0] line_x1 = '0;
	logic signed [W-1:0] line_y1 = '0;
	logic signed [W-1:0] line_x2 = P2_RESET;
	logic signed [W-1:0] line_y2 = P2_RESET;

	logic [TDW-1:0] pending_samples[$];
	scaled_beat_t   expected_scaled[$];
	int             mismatch_count = 0;

	bit             sample_taken   = 1'b0;
	bit             steady_sender  = 1'b0;
	int             burst_left     = 0;
	int             gap_left       = 0;
	rx_pattern_e    rx_pattern     = RX_OPEN;
	int             rx_cycle       = 0;

	two_point_linear_scaler i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Map a sample onto the held line: exact products, quotient truncated
	// toward zero, then clamped between the two y points.
	function automatic scaled_beat_t scale_sample(input logic signed [W-1:0] x);
		scaled_beat_t beat;
		longint       dx;
		longint       dy;
		longint       num;
		longint       quo;
		longint       lo_bound;
		longint       hi_bound;
		beat.data       = '0;
		beat.degenerate = 1'b0;
		dx = longint'(line_x2) - longint'(line_x1);
		if (dx == 0) begin
			beat.degenerate = 1'b1;
			return beat;
		end
		dy  = longint'(line_y2) - longint'(line_y1);
		num = (longint'(x) - longint'(line_x1)) * dy + longint'(line_y1) * dx;
		quo = num / dx;
		lo_bound = (line_y1 < line_y2) ? longint'(line_y1) : longint'(line_y2);
		hi_bound = (line_y1 < line_y2) ? longint'(line_y2) : longint'(line_y1);
		if (quo < lo_bound)
			quo = lo_bound;
		if (quo > hi_bound)
			quo = hi_bound;
		beat.data[W-1:0] = quo[W-1:0];
		return beat;
	endfunction

	// Draw a calibration coordinate, leaning on the extremes and small values.
	function automatic logic signed [W-1:0] pick_coord();
		case ($urandom_range(0, 5))
		0: return SAMPLE_MIN;
		1: return SAMPLE_MAX;
		2: return W'(int'($urandom_range(0, 128)) - 64);
		default: return W'($urandom);
		endcase
	endfunction

	// Draw a sample, mostly between the two x points.
	function automatic logic signed [W-1:0] pick_sample(input logic signed [W-1:0] x1,
			input logic signed [W-1:0] x2);
		int lo;
		int hi;
		lo = (x1 < x2) ? int'(x1) : int'(x2);
		hi = (x1 < x2) ? int'(x2) : int'(x1);
		case ($urandom_range(0, 9))
		6: return x1;
		7: return x2;
		8: return $urandom_range(0, 1) ? SAMPLE_MIN : SAMPLE_MAX;
		9: return W'($urandom);
		default: return W'(lo + int'($urandom_range(hi - lo)));
		endcase
	endfunction

	task automatic queue_sample(input logic signed [W-1:0] x);
		logic [TDW-1:0] word;
		word        = '0;
		word[W-1:0] = x;
		pending_samples.push_back(word);
	endtask

	// Hold until every queued sample has gone in and every result has come out.
	task automatic wait_idle();
		@(negedge clk);
		while (pending_samples.size() != 0 || s_axis_tvalid || expected_scaled.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_point(input logic [CIW-1:0] index, input logic signed [W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data  <= value;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Rewrite all four points, then let the derived line constants settle.
	task automatic load_line(input logic signed [W-1:0] x1, input logic signed [W-1:0] y1,
			input logic signed [W-1:0] x2, input logic signed [W-1:0] y2);
		write_point(REG_P1X, x1);
		write_point(REG_P1Y, y1);
		write_point(REG_P2X, x2);
		write_point(REG_P2Y, y2);
		repeat (2) @(negedge clk);
	endtask

	// Track configuration writes, predict on accepted samples, check results.
	always @(posedge clk) begin
		scaled_beat_t want;
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
				REG_P1X: line_x1 = cfg_data;
				REG_P1Y: line_y1 = cfg_data;
				REG_P2X: line_x2 = cfg_data;
				REG_P2Y: line_y2 = cfg_data;
				endcase
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expected_scaled.push_back(scale_sample(s_axis_tdata[W-1:0]));
				sample_taken = 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_scaled.size() == 0) begin
					$display("%0t: unexpected output beat, tdata %h tuser %b",
						$realtime, m_axis_tdata, m_axis_tuser);
					mismatch_count++;
				end else begin
					want = expected_scaled.pop_front();
					if (m_axis_tdata !== want.data) begin
						$display("%0t: scaled_value expected %h actual %h",
							$realtime, want.data, m_axis_tdata);
						mismatch_count++;
					end
					if (m_axis_tuser !== want.degenerate) begin
						$display("%0t: degenerate_error expected %b actual %b",
							$realtime, want.degenerate, m_axis_tuser);
						mismatch_count++;
					end
				end
			end
		end
	end

	// Sample driver: drop the beat once taken, then present the next one after
	// any gap. Bursts end at random and are sometimes followed by a random gap,
	// never while the sender is in a steady stretch.
	always @(negedge clk) begin
		logic           nxt_valid;
		logic [TDW-1:0] nxt_data;
		nxt_valid = s_axis_tvalid;
		nxt_data  = s_axis_tdata;
		if (arst_n) begin
			if (sample_taken) begin
				void'(pending_samples.pop_front());
				nxt_valid    = 1'b0;
				sample_taken = 1'b0;
			end
			if (!nxt_valid) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_samples.size() > 0) begin
					nxt_valid = 1'b1;
					nxt_data  = pending_samples[0];
					if (burst_left > 0)
						burst_left--;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 32);
						if (steady_sender || $urandom_range(0, 1))
							gap_left = 0;
						else
							gap_left = $urandom_range(1, 8);
					end
				end
			end
		end
		s_axis_tvalid <= nxt_valid;
		s_axis_tdata  <= nxt_data;
	end

	// Result receiver: periodically draw a new stall pattern at random.
	always @(negedge clk) begin
		logic ready;
		ready = 1'b0;
		if (arst_n) begin
			rx_cycle++;
			if (rx_cycle % 300 == 0)
				rx_pattern = rx_pattern_e'($urandom_range(0, 3));
			case (rx_pattern)
			RX_OPEN:   ready = 1'b1;
			RX_COIN:   ready = 1'($urandom_range(0, 1));
			RX_SPARSE: ready = ($urandom_range(0, 3) == 0);
			RX_COMB:   ready = ((rx_cycle % 9) < 5);
			endcase
		end
		m_axis_tready <= ready;
	end

	initial begin
		logic signed [W-1:0] x1;
		logic signed [W-1:0] y1;
		logic signed [W-1:0] x2;
		logic signed [W-1:0] y2;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// reset line: identity from 0 to the top, negatives clamp to 0
		queue_sample(SAMPLE_MIN);
		queue_sample(-16'sd1);
		queue_sample(16'sd0);
		queue_sample(16'sh5555);
		queue_sample(SAMPLE_MAX);

		// full-range ascending line
		wait_idle();
		load_line(SAMPLE_MIN, SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX);
		queue_sample(SAMPLE_MIN);
		queue_sample(SAMPLE_MAX);
		queue_sample(16'shAAAA);
		queue_sample(16'sd0);

		// descending line: clamp range still runs from the lower y up
		wait_idle();
		load_line(SAMPLE_MIN, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MIN);
		queue_sample(SAMPLE_MIN);
		queue_sample(SAMPLE_MAX);
		queue_sample(-16'sd1);
		queue_sample(16'sd1);

		// second point left of the first: negative x span
		wait_idle();
		load_line(SAMPLE_MAX, -16'sd100, SAMPLE_MIN, 16'sd500);
		queue_sample(SAMPLE_MAX);
		queue_sample(SAMPLE_MIN);
		queue_sample(16'sd0);
		queue_sample(16'sd1234);

		// steep line over one step of x: nearly everything clamps
		wait_idle();
		load_line(16'sd0, SAMPLE_MIN, 16'sd1, SAMPLE_MAX);
		queue_sample(16'sd0);
		queue_sample(16'sd1);
		queue_sample(-16'sd1);
		queue_sample(SAMPLE_MAX);

		// both x points equal at the bottom of the range: error, output 0
		wait_idle();
		load_line(SAMPLE_MIN, 16'sd77, SAMPLE_MIN, -16'sd77);
		queue_sample(SAMPLE_MIN);
		queue_sample(SAMPLE_MAX);
		queue_sample(16'sd0);
		queue_sample(16'sh7F00);

		for (int line_no = 0; line_no < RANDOM_LINES; line_no++) begin
			// drain fully before the points move
			wait_idle();
			x1 = pick_coord();
			y1 = pick_coord();
			x2 = ($urandom_range(0, 7) == 0) ? x1 : pick_coord();
			y2 = ($urandom_range(0, 9) == 0) ? y1 : pick_coord();
			load_line(x1, y1, x2, y2);
			steady_sender = ($urandom_range(0, 3) == 0);
			for (int n = 0; n < SAMPLES_PER_LINE; n++)
				queue_sample(pick_sample(x1, x2));
		end

		wait_idle();
		repeat (NS + 8) @(posedge clk);
		if (mismatch_count == 0 && expected_scaled.size() == 0) begin
			$display("two_point_linear_scaler regression: pass");
		end else begin
			$display("two_point_linear_scaler regression: fail");
		end
		$finish;
	end

	// watchdog: far beyond the slowest legal run
	initial begin
		#5_000_000;
		$display("two_point_linear_scaler regression: fail");
		$finish;
	end

endmodule
